### rtl/core/srctl_pkg.sv
// Shared types, key codes and the speed-to-delay table for the stepper ramp controller.
// No dependencies; imported by stepper_ramp_controller.
package srctl_pkg;

   // sizes and reset values
   localparam int          COUNT_DIGITS_DEFAULT = 4;
   localparam int          BCD_SHOWN            = 4;
   localparam logic [7:0]  PHASE_RESET          = 8'h33;
   localparam logic [7:0]  FLOOR_RESET          = 8'd50;
   localparam logic [3:0]  SPEED_RESET          = 4'd5;
   localparam logic [3:0]  SPEED_MAX            = 4'd11;

   // item kinds
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_KEY  = 1'b1;

   // key codes; anything below KEY_DIR is a digit, above KEY_START only stops
   localparam logic [3:0] KEY_DIR    = 4'd10;
   localparam logic [3:0] KEY_FASTER = 4'd11;
   localparam logic [3:0] KEY_SLOWER = 4'd12;
   localparam logic [3:0] KEY_START  = 4'd13;

   typedef struct packed {
      logic       operation;
      logic [3:0] key_code;
   } req_type;

   typedef struct packed {
      logic        phase_valid;
      logic [7:0]  phase_drive;
      logic        running;
      logic        counter_clockwise;
      logic [3:0]  speed_level;
      logic [15:0] count_bcd;
      logic        display_update;
   } rsp_type;

   // target step delay in ticks per speed level; out-of-range levels use the fastest
   function automatic logic [7:0] delay_lookup(input logic [3:0] level);
      logic [7:0] delay;
      case (level)
         4'd0:    delay = 8'd250;
         4'd1:    delay = 8'd125;
         4'd2:    delay = 8'd83;
         4'd3:    delay = 8'd62;
         4'd4:    delay = 8'd50;
         4'd5:    delay = 8'd42;
         4'd6:    delay = 8'd36;
         4'd7:    delay = 8'd32;
         4'd8:    delay = 8'd28;
         4'd9:    delay = 8'd25;
         4'd10:   delay = 8'd22;
         default: delay = 8'd21;
      endcase
      return delay;
   endfunction

endpackage

### rtl/core/stepper_ramp_controller.sv
// Stepper motor controller with keypad command decode and an acceleration ramp.
// Depends on srctl_pkg (payload structs, key codes, delay table).
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------
//   req     | in        | req_valid/req_ready | req_type: operation, key_code
//   rsp     | out       | rsp_valid/rsp_ready | rsp_type: phase, status, count
//   csr     | in        | csr_wr_en           | csr_wr_data: ramp start floor
//
// One beat in, one beat out: the state update and the result
// are computed in the accept cycle and the result lands in the output register.
// req_ready is high while the output register is empty or being drained, so a
// new beat is taken in the same cycle the previous result leaves.
// Reset (synchronous, active high) restores phase 0x33, clockwise, speed 5, count
// zero, motor stopped and floor 50; there is no clearing pass.
module stepper_ramp_controller
   import srctl_pkg::*;
#(
   parameter int COUNT_DIGITS = COUNT_DIGITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   localparam int SHOWN = (COUNT_DIGITS < BCD_SHOWN) ? COUNT_DIGITS : BCD_SHOWN;

   // controller state
   logic [7:0] floor_ff,  floor_in;
   logic [7:0] phase_ff,  phase_in;
   logic       cw_ff,     cw_in;
   logic [3:0] speed_ff,  speed_in;
   logic [7:0] target_ff, target_in;
   logic [7:0] ramp_ff,   ramp_in;
   logic [7:0] reload_ff, reload_in;
   logic       motor_ff,  motor_in;
   logic [3:0] digits_ff [COUNT_DIGITS];
   logic [3:0] digits_in [COUNT_DIGITS];

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff,  rsp_data_in;

   // step helpers
   logic       accept;
   logic [7:0] ramp_dec;
   logic [7:0] reload_next;
   logic [7:0] start_delay;
   logic [7:0] table_delay;
   logic [3:0] digits_dec [COUNT_DIGITS];
   logic       count_zero;
   logic       dec_zero;
   logic       borrow;

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // take the floor register from the config port
   assign floor_in = csr_wr_en ? csr_wr_data : floor_ff;

   // start delay: table target, raised to the floor
   assign table_delay = delay_lookup(speed_ff);
   assign start_delay = (table_delay < floor_ff) ? floor_ff : table_delay;

   // ramp countdown and reload creep toward the target
   assign ramp_dec    = ramp_ff - 8'd1;
   assign reload_next = (target_ff != reload_ff) ? (reload_ff - 8'd1) : reload_ff;

   // BCD decrement with borrow ripple, and zero tests before and after
   always_comb begin
      borrow     = 1'b1;
      count_zero = 1'b1;
      dec_zero   = 1'b1;
      for (int i = 0; i < COUNT_DIGITS; i++) begin
         if (!borrow) begin
            digits_dec[i] = digits_ff[i];
         end else if (digits_ff[i] != 4'd0) begin
            digits_dec[i] = digits_ff[i] - 4'd1;
            borrow        = 1'b0;
         end else begin
            digits_dec[i] = 4'd9;
         end
         if (digits_ff[i] != 4'd0) begin
            count_zero = 1'b0;
         end
         if (digits_dec[i] != 4'd0) begin
            dec_zero = 1'b0;
         end
      end
   end

   // next state and result for the accepted beat
   always_comb begin
      phase_in  = phase_ff;
      cw_in     = cw_ff;
      speed_in  = speed_ff;
      target_in = target_ff;
      ramp_in   = ramp_ff;
      reload_in = reload_ff;
      motor_in  = motor_ff;
      for (int i = 0; i < COUNT_DIGITS; i++) begin
         digits_in[i] = digits_ff[i];
      end
      rsp_data_in = '0;

      if (accept) begin
         if (req_data.operation == OP_KEY) begin
            // every key stops motion first
            motor_in = 1'b0;
            if (req_data.key_code < KEY_DIR) begin
               for (int i = COUNT_DIGITS - 1; i > 0; i--) begin
                  digits_in[i] = digits_ff[i - 1];
               end
               digits_in[0] = req_data.key_code;
            end else begin
               case (req_data.key_code)
                  KEY_DIR: begin
                     cw_in    = !cw_ff;
                     phase_in = cw_ff ? {phase_ff[1:0], phase_ff[7:2]}
                                      : {phase_ff[5:0], phase_ff[7:6]};
                  end
                  KEY_FASTER: begin
                     if (speed_ff < SPEED_MAX) begin
                        speed_in = speed_ff + 4'd1;
                     end
                  end
                  KEY_SLOWER: begin
                     if (speed_ff != 4'd0) begin
                        speed_in = speed_ff - 4'd1;
                     end
                  end
                  KEY_START: begin
                     target_in = table_delay;
                     ramp_in   = start_delay;
                     reload_in = start_delay;
                     motor_in  = 1'b1;
                  end
                  default: begin
                     // stop keys: nothing beyond the stop
                  end
               endcase
            end
         end else if (motor_ff) begin
            // tick: count the ramp down, step when it hits zero
            ramp_in = ramp_dec;
            if (ramp_dec == 8'd0) begin
               reload_in               = reload_next;
               ramp_in                 = reload_next;
               rsp_data_in.phase_valid = 1'b1;
               rsp_data_in.phase_drive = phase_ff;
               phase_in = cw_ff ? {phase_ff[6:0], phase_ff[7]}
                                : {phase_ff[0], phase_ff[7:1]};
               if (!count_zero) begin
                  rsp_data_in.display_update = 1'b1;
                  for (int i = 0; i < COUNT_DIGITS; i++) begin
                     digits_in[i] = digits_dec[i];
                  end
                  if (dec_zero) begin
                     motor_in = 1'b0;
                  end
               end
            end
         end
      end

      // status reflects the state after this beat
      rsp_data_in.running           = motor_in;
      rsp_data_in.counter_clockwise = !cw_in;
      rsp_data_in.speed_level       = speed_in;
      for (int i = 0; i < SHOWN; i++) begin
         rsp_data_in.count_bcd[4*i +: 4] = digits_in[i];
      end
   end

   // hold the result until taken, load a new one on accept
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff     <= FLOOR_RESET;
         phase_ff     <= PHASE_RESET;
         cw_ff        <= 1'b1;
         speed_ff     <= SPEED_RESET;
         target_ff    <= 8'd0;
         ramp_ff      <= 8'd0;
         reload_ff    <= 8'd0;
         motor_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < COUNT_DIGITS; i++) begin
            digits_ff[i] <= 4'd0;
         end
      end else begin
         floor_ff     <= floor_in;
         phase_ff     <= phase_in;
         cw_ff        <= cw_in;
         speed_ff     <= speed_in;
         target_ff    <= target_in;
         ramp_ff      <= ramp_in;
         reload_ff    <= reload_in;
         motor_ff     <= motor_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < COUNT_DIGITS; i++) begin
            digits_ff[i] <= digits_in[i];
         end
      end
   end

   // result payload, loaded only on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
